// ===== hw/rtl/cst_pkg.sv =====
`default_nettype none
package cst_pkg;

  localparam logic [3:0] KIND_ACQUIRE   = 4'd0;
  localparam logic [3:0] KIND_RESERVE   = 4'd1;
  localparam logic [3:0] KIND_SUCCESS   = 4'd2;
  localparam logic [3:0] KIND_FAILURE   = 4'd3;
  localparam logic [3:0] KIND_CLOSE     = 4'd4;
  localparam logic [3:0] KIND_CHECK     = 4'd5;
  localparam logic [3:0] KIND_COUNT     = 4'd6;
  localparam logic [3:0] KIND_NEXT_SEQ  = 4'd7;
  localparam logic [3:0] KIND_RESET_ALL = 4'd8;
  localparam logic [3:0] KIND_CLOSE_ALL = 4'd9;

  localparam logic [1:0] ST_EMPTY      = 2'd0;
  localparam logic [1:0] ST_CONNECTING = 2'd1;
  localparam logic [1:0] ST_READY      = 2'd2;
  localparam logic [1:0] ST_BACKOFF    = 2'd3;

  localparam logic [1:0] ADDR_IDX  = 2'd0;
  localparam logic [1:0] ADDR_CNT  = 2'd1;
  localparam logic [1:0] ADDR_BEST = 2'd2;

  localparam logic [6:0]  HEALTH_RESET = 7'd50;
  localparam logic [6:0]  HEALTH_MAX   = 7'd100;
  localparam logic [6:0]  HEALTH_PENALTY = 7'd10;
  localparam logic [6:0]  HEALTH_BONUS = 7'd8;
  localparam logic [3:0]  STREAK_MAX   = 4'd8;
  localparam logic [2:0]  SHIFT_MAX    = 3'd5;
  localparam logic [15:0] BASE_RESET   = 16'd100;
  localparam logic [19:0] MAX_RESET    = 20'd3000;
  localparam logic [0:0]  REG_BASE     = 1'b0;
  localparam logic [0:0]  REG_MAX      = 1'b1;

  typedef struct packed {
    logic [1:0]  state;
    logic        sock;
    logic        conn;
    logic        ident;
    logic [63:0] key;
    logic [6:0]  health;
    logic [3:0]  streak;
    logic [31:0] deadline;
    logic [31:0] last;
    logic [31:0] fails;
    logic [63:0] seq;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    state: ST_EMPTY, sock: 1'b0, conn: 1'b0, ident: 1'b0, key: 64'd0,
    health: HEALTH_RESET, streak: 4'd0, deadline: 32'd0, last: 32'd0,
    fails: 32'd0, seq: 64'd0
  };

  typedef struct packed {
    logic       load;
    logic       scan;
    logic       write;
    logic       fin;
    logic [1:0] addr_sel;
  } cmd_t;

  typedef struct packed {
    logic sweep;
    logic pick;
    logic scan_op;
    logic scan_last;
    logic have;
  } status_t;

  function automatic logic tick_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/connection_slot_table.sv =====
// Connection slot table: a set of SLOTS connection slots keyed by endpoint.
// Input channel (in_valid/in_ready) carries one operation per transaction:
// kind, slot_index, endpoint_key and now. Output channel (out_valid/
// out_ready) returns exactly one result transaction per operation.
// Configuration: cfg_we writes cfg_data to base_backoff (low 16 bits, index 0) or
// max_backoff (index 1); write only while no operation is open.
// Success, failure, close, next sequence and unknown kinds go from
// acceptance through the execute state to the result register. Acquire,
// reserve, check backoff, count, reset all and close all walk the slots one
// per cycle through the single entry read port, then take an apply step.
// One operation is in flight at a time; a new one is taken once the
// previous result is loaded into the output register, even if that result
// has not yet been taken.
// Reset (rst, synchronous) empties every slot, sets health to 50 and
// restores the register defaults; no clearing pass is needed.
// If the receiver stalls, the result holds and the next operation waits at
// its final step until the output register frees up.
`default_nettype none
module connection_slot_table #(
  parameter int SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [3:0]  kind,
  input  wire  [3:0]  slot_index,
  input  wire  [63:0] endpoint_key,
  input  wire  [31:0] now,
  output logic        out_valid,
  input  wire         out_ready,
  output logic        found,
  output logic [3:0]  slot_out,
  output logic [31:0] ticks_out,
  output logic [4:0]  active_count,
  output logic [63:0] seq_value,
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [19:0] cfg_data
);

  cst_pkg::cmd_t    cmd;
  cst_pkg::status_t stat;

  cst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  cst_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .kind         (kind),
    .slot_index   (slot_index),
    .endpoint_key (endpoint_key),
    .now          (now),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .found        (found),
    .slot_out     (slot_out),
    .ticks_out    (ticks_out),
    .active_count (active_count),
    .seq_value    (seq_value)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/cst_ctrl.sv =====
`default_nettype none
module cst_ctrl (
  input  wire            clk,
  input  wire            rst,
  input  wire            in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire            out_ready,
  output cst_pkg::cmd_t  cmd,
  input  cst_pkg::status_t stat
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_APPLY = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.addr_sel = cst_pkg::ADDR_IDX;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.scan_op) begin
          state_next = S_SCAN;
        end else if (out_free) begin
          cmd.write  = 1'b1;
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.addr_sel = cst_pkg::ADDR_CNT;
        cmd.scan     = 1'b1;
        cmd.write    = stat.sweep;
        if (stat.scan_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.addr_sel = cst_pkg::ADDR_BEST;
        if (out_free) begin
          cmd.write  = stat.pick && stat.have;
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cst_dp.sv =====
`default_nettype none
module cst_dp #(
  parameter int SLOTS = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  cst_pkg::cmd_t     cmd,
  output cst_pkg::status_t  stat,
  input  wire [3:0]         kind,
  input  wire [3:0]         slot_index,
  input  wire [63:0]        endpoint_key,
  input  wire [31:0]        now,
  input  wire               cfg_we,
  input  wire               cfg_index,
  input  wire [19:0]        cfg_data,
  output logic              found,
  output logic [3:0]        slot_out,
  output logic [31:0]       ticks_out,
  output logic [4:0]        active_count,
  output logic [63:0]       seq_value
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cst_pkg::entry_t ent [SLOTS];
  cst_pkg::entry_t cur;
  cst_pkg::entry_t upd;

  logic [15:0] base_backoff;
  logic [19:0] max_backoff;

  logic [3:0]  kind_r;
  logic [3:0]  idx_r;
  logic [63:0] key_r;
  logic [31:0] now_r;

  logic [IW-1:0] cnt;
  logic [IW-1:0] best;
  logic [IW-1:0] addr;
  logic          have;
  logic [1:0]    lead_rank;
  logic [6:0]    best_health;
  logic [31:0]   best_last;
  logic [31:0]   best_fails;
  logic [31:0]   tick_r;
  logic [4:0]    count_r;

  logic          idx_ok;
  logic          wr_ok;
  logic [3:0]    streak_new;
  logic [2:0]    sh;
  logic [20:0]   iv_raw;
  logic [20:0]   iv;
  logic [63:0]   seq_cur;
  logic [1:0]    rank;
  logic          better;
  logic          key_eq;
  logic          m_acq;
  logic          m_res;
  logic          m_chk;
  logic          m_cnt;

  assign idx_ok = (32'(idx_r) < 32'(SLOTS));

  always_comb begin
    case (cmd.addr_sel)
      cst_pkg::ADDR_CNT:  addr = cnt;
      cst_pkg::ADDR_BEST: addr = best;
      default:            addr = IW'({{IW{1'b0}}, idx_r});
    endcase
  end

  assign cur = ent[addr];

  assign wr_ok = idx_ok && (kind_r == cst_pkg::KIND_SUCCESS || kind_r == cst_pkg::KIND_FAILURE ||
                            kind_r == cst_pkg::KIND_CLOSE || kind_r == cst_pkg::KIND_NEXT_SEQ);

  assign streak_new = (cur.streak < cst_pkg::STREAK_MAX) ? cur.streak + 4'd1 : cur.streak;
  always_comb begin
    if (streak_new <= 4'd1) begin
      sh = 3'd0;
    end else if (streak_new - 4'd1 > 4'(cst_pkg::SHIFT_MAX)) begin
      sh = cst_pkg::SHIFT_MAX;
    end else begin
      sh = 3'(streak_new - 4'd1);
    end
  end
  assign iv_raw = {5'd0, base_backoff} << sh;
  assign iv     = (iv_raw > {1'b0, max_backoff}) ? {1'b0, max_backoff} : iv_raw;
  assign seq_cur = (cur.seq == 64'd0) ? 64'd1 : cur.seq;

  assign key_eq = (cur.key == key_r);
  assign m_acq  = cur.sock && !cur.conn && key_eq;
  assign m_res  = !cur.sock && !cur.conn;
  assign m_chk  = !cur.sock && (cur.deadline != 32'd0) && key_eq &&
                  cst_pkg::tick_before(now_r, cur.deadline);
  assign m_cnt  = key_eq && (cur.sock || cur.conn);

  always_comb begin
    if (cur.state == cst_pkg::ST_EMPTY && !cur.ident) begin
      rank = 2'd0;
    end else if (cur.state == cst_pkg::ST_EMPTY) begin
      rank = 2'd1;
    end else if (cur.state == cst_pkg::ST_BACKOFF) begin
      rank = 2'd2;
    end else begin
      rank = 2'd3;
    end
  end

  always_comb begin
    if (rank != lead_rank) begin
      better = rank < lead_rank;
    end else if (cur.health != best_health) begin
      better = cur.health < best_health;
    end else if (cur.last != best_last) begin
      better = cst_pkg::tick_before(cur.last, best_last);
    end else begin
      better = cur.fails > best_fails;
    end
  end

  always_comb begin
    upd = cur;
    case (kind_r)
      cst_pkg::KIND_ACQUIRE: begin
        upd.last   = now_r;
        upd.health = (cur.health >= 7'd99) ? cst_pkg::HEALTH_MAX : cur.health + 7'd1;
        upd.state  = cst_pkg::ST_READY;
      end
      cst_pkg::KIND_RESERVE: begin
        upd.conn  = 1'b1;
        upd.last  = now_r;
        upd.state = cst_pkg::ST_CONNECTING;
      end
      cst_pkg::KIND_SUCCESS: begin
        upd.key      = key_r;
        upd.ident    = 1'b1;
        upd.streak   = 4'd0;
        upd.deadline = 32'd0;
        upd.health   = (cur.health >= cst_pkg::HEALTH_MAX - cst_pkg::HEALTH_BONUS) ?
                       cst_pkg::HEALTH_MAX : cur.health + cst_pkg::HEALTH_BONUS;
        upd.last     = now_r;
        upd.sock     = 1'b1;
        upd.conn     = 1'b0;
        upd.state    = cst_pkg::ST_READY;
      end
      cst_pkg::KIND_FAILURE: begin
        upd.key      = key_r;
        upd.ident    = 1'b1;
        upd.streak   = streak_new;
        upd.deadline = now_r + {11'd0, iv};
        upd.fails    = cur.fails + 32'd1;
        upd.health   = (cur.health <= cst_pkg::HEALTH_PENALTY) ? 7'd0 :
                       cur.health - cst_pkg::HEALTH_PENALTY;
        upd.conn     = 1'b0;
        upd.state    = cst_pkg::ST_BACKOFF;
      end
      cst_pkg::KIND_CLOSE: begin
        upd.sock  = 1'b0;
        upd.conn  = 1'b0;
        upd.seq   = 64'd0;
        upd.state = (cur.deadline != 32'd0 && cst_pkg::tick_before(now_r, cur.deadline)) ?
                    cst_pkg::ST_BACKOFF : cst_pkg::ST_EMPTY;
      end
      cst_pkg::KIND_NEXT_SEQ: begin
        upd.last = now_r;
        upd.seq  = seq_cur + 64'd1;
      end
      cst_pkg::KIND_RESET_ALL: begin
        upd.streak   = 4'd0;
        upd.deadline = 32'd0;
        upd.state    = cur.conn ? cst_pkg::ST_CONNECTING :
                       (cur.sock ? cst_pkg::ST_READY : cst_pkg::ST_EMPTY);
      end
      cst_pkg::KIND_CLOSE_ALL: begin
        upd.sock     = 1'b0;
        upd.conn     = 1'b0;
        upd.seq      = 64'd0;
        upd.key      = 64'd0;
        upd.ident    = 1'b0;
        upd.streak   = 4'd0;
        upd.deadline = 32'd0;
        upd.state    = cst_pkg::ST_EMPTY;
      end
      default: upd = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        ent[i] <= cst_pkg::ENTRY_RESET;
      end
      base_backoff <= cst_pkg::BASE_RESET;
      max_backoff  <= cst_pkg::MAX_RESET;
    end else begin
      if (cmd.write && (cmd.addr_sel != cst_pkg::ADDR_IDX || wr_ok)) begin
        ent[addr] <= upd;
      end
      if (cfg_we) begin
        if (cfg_index == cst_pkg::REG_BASE) begin
          base_backoff <= cfg_data[15:0];
        end else begin
          max_backoff <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= kind;
      idx_r   <= slot_index;
      key_r   <= endpoint_key;
      now_r   <= now;
      cnt     <= '0;
      have    <= 1'b0;
      count_r <= 5'd0;
      best    <= '0;
    end else if (cmd.scan) begin
      cnt <= cnt + IW'(1);
      case (kind_r)
        cst_pkg::KIND_ACQUIRE: begin
          if (!have && m_acq) begin
            have <= 1'b1;
            best <= cnt;
          end
        end
        cst_pkg::KIND_RESERVE: begin
          if (m_res && (!have || better)) begin
            have        <= 1'b1;
            best        <= cnt;
            lead_rank   <= rank;
            best_health <= cur.health;
            best_last   <= cur.last;
            best_fails  <= cur.fails;
          end
        end
        cst_pkg::KIND_CHECK: begin
          if (!have && m_chk) begin
            have   <= 1'b1;
            tick_r <= cur.deadline - now_r;
          end
        end
        cst_pkg::KIND_COUNT: begin
          if (m_cnt && count_r != 5'd31) begin
            count_r <= count_r + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      found        <= 1'b0;
      slot_out     <= 4'd0;
      ticks_out    <= 32'd0;
      active_count <= 5'd0;
      seq_value    <= 64'd0;
      case (kind_r)
        cst_pkg::KIND_ACQUIRE, cst_pkg::KIND_RESERVE: begin
          found    <= have;
          slot_out <= have ? 4'({4'd0, best}) : 4'd0;
        end
        cst_pkg::KIND_CHECK: begin
          found     <= have;
          ticks_out <= have ? tick_r : 32'd0;
        end
        cst_pkg::KIND_COUNT:    active_count <= count_r;
        cst_pkg::KIND_FAILURE:  ticks_out <= idx_ok ? {11'd0, iv} : 32'd0;
        cst_pkg::KIND_NEXT_SEQ: seq_value <= idx_ok ? seq_cur : 64'd0;
        default: ;
      endcase
    end
  end

  assign stat.scan_op = (kind_r == cst_pkg::KIND_ACQUIRE || kind_r == cst_pkg::KIND_RESERVE ||
                         kind_r == cst_pkg::KIND_CHECK || kind_r == cst_pkg::KIND_COUNT ||
                         kind_r == cst_pkg::KIND_RESET_ALL || kind_r == cst_pkg::KIND_CLOSE_ALL);
  assign stat.sweep = (kind_r == cst_pkg::KIND_RESET_ALL || kind_r == cst_pkg::KIND_CLOSE_ALL);
  assign stat.pick  = (kind_r == cst_pkg::KIND_ACQUIRE || kind_r == cst_pkg::KIND_RESERVE);
  assign stat.scan_last = (cnt == IW'(SLOTS - 1));
  assign stat.have  = have;

endmodule
`default_nettype wire
